// File: sv/hpv_pkg.sv
// ----------------------------------------------------------------------------
// hpv_pkg
// Shared types and constants of the Hermite path velocity block.
// ----------------------------------------------------------------------------
package hpv_pkg;

  localparam int COORD_FRAC_BITS = 12;

  // Squared-length threshold below which the start-to-target vector counts as
  // zero: ceil(2^(2F) / 1e8) in point units squared.
  localparam longint unsigned EZ_THR =
    ((64'd1 << (2 * COORD_FRAC_BITS)) + 64'd99999999) / 64'd100000000;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam logic signed [40:0] OUT_MAX = 41'sd549755813887;
  localparam logic signed [40:0] OUT_MIN = -41'sd549755813888;

  typedef enum logic [2:0] {
    CFG_START_X  = 3'd0,
    CFG_START_Y  = 3'd1,
    CFG_TARGET_X = 3'd2,
    CFG_TARGET_Y = 3'd3,
    CFG_HEADING_X = 3'd4,
    CFG_HEADING_Y = 3'd5,
    CFG_DURATION = 3'd6
  } hpv_cfg_e;

  // Per-configuration path terms, produced by the tangent sequencer.
  typedef struct packed {
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] tx;
    logic signed [33:0] ty;
    logic               end_zero;
  } hpv_tan_t;

endpackage

// File: sv/hpv_if.sv
// ----------------------------------------------------------------------------
// hpv_if
// Valid/ready stream interfaces for time samples and velocity results.
// ----------------------------------------------------------------------------
interface hpv_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] sample_time;

  modport source (output valid, output sample_time, input ready);
  modport sink   (input valid, input sample_time, output ready);
endinterface

interface hpv_out_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] vel_x;
  logic signed [39:0] vel_y;
  logic               saturated;

  modport source (output valid, output vel_x, output vel_y, output saturated, input ready);
  modport sink   (input valid, input vel_x, input vel_y, input saturated, output ready);
endinterface

// File: sv/hpv_tangent.sv
// ----------------------------------------------------------------------------
// hpv_tangent
// Multi-cycle sequencer: point delta, half distance, unit heading and the
// start tangent, recomputed after reset and after every register write.
// ----------------------------------------------------------------------------
module hpv_tangent import hpv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               restart_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [15:0] heading_x_i,
  input  logic signed [15:0] heading_y_i,
  output hpv_tan_t           tan_o,
  output logic               done_o
);

  typedef enum logic [3:0] {
    ST_SQX, ST_SQY, ST_SQHX, ST_SQHY, ST_HALF, ST_RL,
    ST_DIVX, ST_DIVY, ST_MULX, ST_MULY, ST_DONE
  } state_e;

  state_e state_q;

  logic signed [32:0] dx_c, dy_c, dx_q, dy_q;
  logic [32:0] dxm33, dym33;
  logic [31:0] dxm, dym;
  logic [15:0] hxm, hym;
  logic [63:0] sx_q, sy_q, n_q, r_q;
  logic [31:0] hl_q, half_q, rl_q, ux_q, uy_q, rem_q, quo_q;
  logic [63:0] dvd_q;
  logic [5:0]  cnt_q;
  logic signed [33:0] tx_q, ty_q;
  logic        ez_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [6:0]  sh;
  logic [63:0] bit_v, rsum, r_nx, n_nx;
  logic [32:0] rem2;
  logic        ge;
  logic [31:0] rem_nx;
  logic [33:0] mx;

  assign dx_c  = 33'(target_x_i) - 33'(start_x_i);
  assign dy_c  = 33'(target_y_i) - 33'(start_y_i);
  assign dxm33 = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
  assign dym33 = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
  assign dxm   = dxm33[31:0];
  assign dym   = dym33[31:0];
  assign hxm   = heading_x_i[15] ? 16'(-heading_x_i) : 16'(heading_x_i);
  assign hym   = heading_y_i[15] ? 16'(-heading_y_i) : 16'(heading_y_i);

  // One shared 32x32 multiplier.
  always_comb begin
    unique case (state_q)
      ST_SQX:  begin mul_a = dxm;           mul_b = dxm;           end
      ST_SQY:  begin mul_a = dym;           mul_b = dym;           end
      ST_SQHX: begin mul_a = {16'b0, hxm};  mul_b = {16'b0, hxm};  end
      ST_SQHY: begin mul_a = {16'b0, hym};  mul_b = {16'b0, hym};  end
      ST_MULX: begin mul_a = ux_q;          mul_b = half_q;        end
      ST_MULY: begin mul_a = uy_q;          mul_b = half_q;        end
      default: begin mul_a = '0;            mul_b = '0;            end
    endcase
  end
  assign prod = 64'(mul_a) * 64'(mul_b);
  assign mx   = prod[63:30];

  // Integer square root, one bit pair per cycle.
  always_comb begin
    sh    = 7'd62 - {1'b0, cnt_q[4:0], 1'b0};
    bit_v = 64'd1 << sh;
    rsum  = r_q + bit_v;
    if (n_q >= rsum) begin
      n_nx = n_q - rsum;
      r_nx = (r_q >> 1) + bit_v;
    end else begin
      n_nx = n_q;
      r_nx = r_q >> 1;
    end
  end

  // Restoring divide by rl, one quotient bit per cycle.
  assign rem2   = {rem_q, dvd_q[63]};
  assign ge     = rem2 >= {1'b0, rl_q};
  assign rem_nx = ge ? 32'(rem2 - {1'b0, rl_q}) : rem2[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SQX;
      cnt_q   <= '0;
    end else if (restart_i) begin
      state_q <= ST_SQX;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_SQX: begin
          sx_q    <= prod;
          dx_q    <= dx_c;
          dy_q    <= dy_c;
          state_q <= ST_SQY;
        end
        ST_SQY: begin
          sy_q    <= prod;
          state_q <= ST_SQHX;
        end
        ST_SQHX: begin
          hl_q    <= prod[31:0];
          state_q <= ST_SQHY;
        end
        ST_SQHY: begin
          hl_q  <= hl_q + prod[31:0];
          ez_q  <= (dxm < 32'd65536) && (dym < 32'd65536) &&
                   ((65'(sx_q) + 65'(sy_q)) < 65'(EZ_THR));
          n_q   <= (sx_q >> 2) + (sy_q >> 2) +
                   64'(({1'b0, sx_q[1:0]} + {1'b0, sy_q[1:0]}) >> 2);
          r_q   <= '0;
          cnt_q <= '0;
          state_q <= ST_HALF;
        end
        ST_HALF: begin
          if (cnt_q == 6'd31) begin
            half_q  <= r_nx[31:0];
            n_q     <= {hl_q, 32'b0};
            r_q     <= '0;
            cnt_q   <= '0;
            state_q <= ST_RL;
          end else begin
            n_q   <= n_nx;
            r_q   <= r_nx;
            cnt_q <= cnt_q + 6'd1;
          end
        end
        ST_RL: begin
          if (cnt_q == 6'd31) begin
            rl_q  <= r_nx[31:0];
            cnt_q <= '0;
            rem_q <= '0;
            quo_q <= '0;
            dvd_q <= {2'b0, hxm, 46'b0};
            if (hl_q < 32'd3) begin
              tx_q    <= '0;
              ty_q    <= '0;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_DIVX;
            end
          end else begin
            n_q   <= n_nx;
            r_q   <= r_nx;
            cnt_q <= cnt_q + 6'd1;
          end
        end
        ST_DIVX, ST_DIVY: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            rem_q <= '0;
            quo_q <= '0;
            dvd_q <= {2'b0, hym, 46'b0};
            if (state_q == ST_DIVX) begin
              ux_q    <= {quo_q[30:0], ge};
              state_q <= ST_DIVY;
            end else begin
              uy_q    <= {quo_q[30:0], ge};
              state_q <= ST_MULX;
            end
          end else begin
            rem_q <= rem_nx;
            quo_q <= {quo_q[30:0], ge};
            dvd_q <= dvd_q << 1;
          end
        end
        ST_MULX: begin
          tx_q    <= heading_x_i[15] ? 34'(-mx) : mx;
          state_q <= ST_MULY;
        end
        ST_MULY: begin
          ty_q    <= heading_y_i[15] ? 34'(-mx) : mx;
          state_q <= ST_DONE;
        end
        default: state_q <= ST_DONE;
      endcase
    end
  end

  assign tan_o.dx       = 34'(dx_q);
  assign tan_o.dy       = 34'(dy_q);
  assign tan_o.tx       = tx_q;
  assign tan_o.ty       = ty_q;
  assign tan_o.end_zero = ez_q;
  assign done_o         = (state_q == ST_DONE);

endmodule

// File: sv/hpv_ntime.sv
// ----------------------------------------------------------------------------
// hpv_ntime
// Pipelined normalized time: a = min(floor(t * 2^16 / duration), 1.0).
// ----------------------------------------------------------------------------
module hpv_ntime import hpv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [23:0] dur_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] st_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [16:0] a_o
);

  localparam int NS = 5;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;
  logic [23:0]   st_q;
  logic [23:0]   rem_q  [1:NS-1];
  logic [15:0]   quo_q  [1:NS-1];
  logic          full_q [1:NS-1];
  logic [39:0]   step_r [1:NS-1];

  // Four quotient bits; remainder stays below the divisor.
  function automatic logic [39:0] div4(input logic [23:0] rem, input logic [15:0] quo,
                                       input logic [23:0] dur);
    logic [24:0] r2;
    logic [23:0] r;
    logic [15:0] q;
    r = rem;
    q = quo;
    for (int i = 0; i < 4; i++) begin
      r2 = {r, 1'b0};
      if (r2 >= {1'b0, dur}) begin
        r = 24'(r2 - {1'b0, dur});
        q = {q[14:0], 1'b1};
      end else begin
        r = r2[23:0];
        q = {q[14:0], 1'b0};
      end
    end
    return {r, q};
  endfunction

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign step_r[1] = div4(st_q, 16'b0, dur_i);
  for (genvar k = 2; k < NS; k++) begin : g_step
    assign step_r[k] = div4(rem_q[k-1], quo_q[k-1], dur_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) st_q <= st_i;
    if (en[1] && v_q[0]) begin
      full_q[1] <= (dur_i == 24'd0) || (st_q >= dur_i);
      rem_q[1]  <= step_r[1][39:16];
      quo_q[1]  <= step_r[1][15:0];
    end
    for (int k = 2; k < NS; k++) begin
      if (en[k] && v_q[k-1]) begin
        full_q[k] <= full_q[k-1];
        rem_q[k]  <= step_r[k][39:16];
        quo_q[k]  <= step_r[k][15:0];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign a_o         = full_q[NS-1] ? ONE_Q16 : {1'b0, quo_q[NS-1]};

endmodule

// File: sv/hpv_eval.sv
// ----------------------------------------------------------------------------
// hpv_eval
// Pipelined Hermite derivative bases, split products, rounding and clipping.
// ----------------------------------------------------------------------------
module hpv_eval import hpv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hpv_tan_t           tan_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [16:0]        a_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [39:0] vel_x_o,
  output logic signed [39:0] vel_y_o,
  output logic               sat_o
);

  localparam int NS = 5;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  logic [32:0]        a2_q, as_q;
  logic signed [36:0] kd_q, kt_q;
  logic signed [52:0] pxl_q, pxh_q, pyl_q, pyh_q;
  logic signed [52:0] qxl_q, qxh_q, qyl_q, qyh_q;
  logic signed [40:0] rx_q, ry_q;

  logic signed [39:0] sa2, sas, h1, h2, h4, kd_c;
  logic signed [18:0] kd_lo, kd_hi, kt_lo, kt_hi;
  logic signed [71:0] sum_x, sum_y;
  logic               clip_x, clip_y;

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // Bases in Q.32, coefficients in Q.33.
  always_comb begin
    sa2  = $signed({7'b0, a2_q});
    sas  = $signed({7'b0, as_q});
    h1   = 40'sd6 * sa2 - 40'sd6 * sas;
    h2   = 40'sd3 * sa2 - 40'sd4 * sas + (40'sd1 <<< 32);
    h4   = 40'sd3 * sa2 - 40'sd2 * sas;
    kd_c = tan_i.end_zero ? -(40'sd2 * h1) : h4 - 40'sd2 * h1;
  end

  assign kd_lo = $signed({1'b0, kd_q[17:0]});
  assign kd_hi = kd_q[36:18];
  assign kt_lo = $signed({1'b0, kt_q[17:0]});
  assign kt_hi = kt_q[36:18];

  // (d*kd + t*kt + 2^32) >> 33
  assign sum_x = 72'(pxl_q) + (72'(pxh_q) <<< 18) + 72'(qxl_q) + (72'(qxh_q) <<< 18)
               + (72'sd1 <<< 32);
  assign sum_y = 72'(pyl_q) + (72'(pyh_q) <<< 18) + 72'(qyl_q) + (72'(qyh_q) <<< 18)
               + (72'sd1 <<< 32);

  assign clip_x = (rx_q > OUT_MAX) || (rx_q < OUT_MIN);
  assign clip_y = (ry_q > OUT_MAX) || (ry_q < OUT_MIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      a2_q <= 33'(a_i) * 33'(a_i);
      as_q <= {a_i, 16'b0};
    end
    if (en[1] && v_q[0]) begin
      kd_q <= 37'(kd_c);
      kt_q <= 37'(40'sd2 * h2);
    end
    if (en[2] && v_q[1]) begin
      pxl_q <= tan_i.dx * kd_lo;
      pxh_q <= tan_i.dx * kd_hi;
      pyl_q <= tan_i.dy * kd_lo;
      pyh_q <= tan_i.dy * kd_hi;
      qxl_q <= tan_i.tx * kt_lo;
      qxh_q <= tan_i.tx * kt_hi;
      qyl_q <= tan_i.ty * kt_lo;
      qyh_q <= tan_i.ty * kt_hi;
    end
    if (en[3] && v_q[2]) begin
      rx_q <= 41'(sum_x >>> 33);
      ry_q <= 41'(sum_y >>> 33);
    end
    if (en[4] && v_q[3]) begin
      vel_x_o <= (rx_q > OUT_MAX) ? OUT_MAX[39:0] :
                 (rx_q < OUT_MIN) ? OUT_MIN[39:0] : rx_q[39:0];
      vel_y_o <= (ry_q > OUT_MAX) ? OUT_MAX[39:0] :
                 (ry_q < OUT_MIN) ? OUT_MIN[39:0] : ry_q[39:0];
      sat_o   <= clip_x || clip_y;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

endmodule

// File: sv/hermite_path_velocity_top.sv
// ----------------------------------------------------------------------------
// hermite_path_velocity_top
// Velocity of a 2D cubic Hermite path at a given time sample.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : time samples (sample_time, Q8.16 s), one transfer per cycle while ready.
//   out_o : vel_x / vel_y (Q28.12 per normalized time) and saturated.
//   cfg   : cfg_we_i writes cfg_data_i to register cfg_idx_i (start, target,
//           heading, duration); no read-back.
// Pipeline: five stages of time normalization (sample register, then 4
//   quotient bits per stage) and five of evaluation (bases, coefficients,
//   split products, sum/round, clip).
// Throughput: one sample per cycle outside tangent setup and back-pressure;
//   stages stall individually, so bubbles are absorbed while out_o.ready is low.
// Tangent setup: after reset and after every register write a sequencer
//   recomputes the distance, unit heading and start tangent (two 32-step
//   square roots, two 64-step divides, six multiplies); when the heading is
//   near zero the divides and the last two multiplies are skipped. in_i
//   is not ready during setup; writes restart it.
// Reset: registers return to their default path, pipeline empties.
// ----------------------------------------------------------------------------
module hermite_path_velocity_top import hpv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hpv_in_if.sink      in_i,
  hpv_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic signed [31:0] start_x_q, start_y_q, target_x_q, target_y_q;
  logic signed [15:0] heading_x_q, heading_y_q;
  logic [23:0]        duration_q;

  hpv_tan_t    tan;
  logic        tan_done;
  logic        nt_in_ready, nt_out_valid, ev_in_ready;
  logic [16:0] a_norm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q   <= 32'sd0;
      start_y_q   <= 32'sd0;
      target_x_q  <= 32'sd4096000;
      target_y_q  <= 32'sd4096000;
      heading_x_q <= 16'sd16384;
      heading_y_q <= 16'sd0;
      duration_q  <= 24'd131072;
    end else if (cfg_we_i) begin
      unique case (hpv_cfg_e'(cfg_idx_i))
        CFG_START_X:   start_x_q   <= cfg_data_i;
        CFG_START_Y:   start_y_q   <= cfg_data_i;
        CFG_TARGET_X:  target_x_q  <= cfg_data_i;
        CFG_TARGET_Y:  target_y_q  <= cfg_data_i;
        CFG_HEADING_X: heading_x_q <= cfg_data_i[15:0];
        CFG_HEADING_Y: heading_y_q <= cfg_data_i[15:0];
        CFG_DURATION:  duration_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  hpv_tangent u_tangent (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_we_i),
    .start_x_i   (start_x_q),
    .start_y_i   (start_y_q),
    .target_x_i  (target_x_q),
    .target_y_i  (target_y_q),
    .heading_x_i (heading_x_q),
    .heading_y_i (heading_y_q),
    .tan_o       (tan),
    .done_o      (tan_done)
  );

  // Samples are held off until the tangent terms are settled.
  assign in_i.ready = nt_in_ready && tan_done;

  hpv_ntime u_ntime (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dur_i       (duration_q),
    .in_valid_i  (in_i.valid && tan_done),
    .in_ready_o  (nt_in_ready),
    .st_i        (in_i.sample_time),
    .out_valid_o (nt_out_valid),
    .out_ready_i (ev_in_ready),
    .a_o         (a_norm)
  );

  hpv_eval u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tan_i       (tan),
    .in_valid_i  (nt_out_valid),
    .in_ready_o  (ev_in_ready),
    .a_i         (a_norm),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .vel_x_o     (out_o.vel_x),
    .vel_y_o     (out_o.vel_y),
    .sat_o       (out_o.saturated)
  );

endmodule
